[src/sntp_offset_estimator_assert.svh]
// assertion macros for the sntp offset estimator
`ifndef SNTP_OFFSET_ESTIMATOR_ASSERT_SVH
`define SNTP_OFFSET_ESTIMATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SNTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SNTP_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> nxt) else $error(msg);
`else
`define SNTP_ASSERT(label, clk, rst_n, prop, msg)
`define SNTP_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

[src/sntp_pkg.sv]
// shared constants for the sntp offset estimator
package sntp_pkg;
    localparam int MAX_SERVERS_DEF = 16;
    localparam int WEIGHT_FRAC_DEF = 24;
    localparam logic signed [31:0] RANGE_LIMIT = 32'sh001F_FF00;
    localparam int MS_SHIFT = 10;
    localparam int FRAC_SHIFT = 22;
    localparam int IN_BITS = 289;
    localparam int IN_BYTES_BITS = 296;
    localparam int OUT_BITS = 135;
    localparam int OUT_BYTES_BITS = 136;
endpackage

[src/sntp_offset_estimator.sv]
// sntp reply processing: delay, offset and weighted skew average
//
//  channel  dir  payload
//  s_axis   in   t1,t4,t2,t3 stamps, echoed frac, present; tlast = last_server
//  m_axis   out  accepted,rtt,offset,warn,fine,coarse,used; tlast = round_done
//
// one request at a time; a request not counted into the average goes from its accept
// through DIFF, FIN and OUT to the next s_tready, plus any wait for m_tready
// a counted reply adds a 64-step restoring reciprocal and the accumulate
// a round end with nonzero weight adds a 64-step restoring divide and clamp
// s_tready is low while a request is in work or its result waits unread
// aresetn synchronously clears the state machine, coarse offset, skew and running sums
`include "sntp_offset_estimator_assert.svh"
module sntp_offset_estimator #(
    parameter int MAX_SERVERS = sntp_pkg::MAX_SERVERS_DEF,
    parameter int WEIGHT_FRAC_BITS = sntp_pkg::WEIGHT_FRAC_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // send_sec, send_frac, arrive_sec, arrive_frac, server_rx_sec,
    // server_rx_frac, server_tx_sec, server_tx_frac, echoed_frac, reply_present
    input  logic [sntp_pkg::IN_BYTES_BITS-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // accepted, round_trip, clock_offset, range_warning, fine_skew,
    // coarse_skew, servers_used
    output logic [sntp_pkg::OUT_BYTES_BITS-1:0] m_tdata,
    output logic m_tlast
);
    import sntp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_RECIP = 3'd2;
    localparam logic [2:0] ST_ACC = 3'd3;
    localparam logic [2:0] ST_DIV = 3'd4;
    localparam logic [2:0] ST_FIN = 3'd5;
    localparam logic [2:0] ST_OUT = 3'd6;
    localparam logic [2:0] ST_SKEW = 3'd7;
    localparam logic [4:0] CAP = (MAX_SERVERS > 31) ? 5'd31 : 5'(MAX_SERVERS);

    logic [2:0] state_reg;
    logic [IN_BITS-1:0] in_reg;
    logic last_reg;
    logic coarse_done_reg;
    logic [31:0] coarse_reg;
    logic signed [31:0] skew_reg;
    logic signed [63:0] wsum_reg;
    logic [31:0] wtot_reg;
    logic [4:0] count_reg;
    logic acc_reg, warn_reg;
    logic signed [31:0] rtt_reg, off_reg;
    logic [4:0] used_reg;
    // shared serial divider
    logic [63:0] num_reg, quo_reg;
    logic [64:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0] cnt_reg;
    logic neg_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast = last_reg;
    assign m_tdata = {1'b0, used_reg, coarse_reg, skew_reg, warn_reg, off_reg,
                      rtt_reg, acc_reg};

    wire [31:0] t1s = in_reg[31:0],    t1f = in_reg[63:32];
    wire [31:0] t4s = in_reg[95:64],   t4f = in_reg[127:96];
    wire [31:0] t2s = in_reg[159:128], t2f = in_reg[191:160];
    wire [31:0] t3s = in_reg[223:192], t3f = in_reg[255:224];
    wire [31:0] echo = in_reg[287:256];
    wire present = in_reg[288];
    wire acc_w = present && (echo == t1f);
    wire [31:0] cor = coarse_done_reg ? 32'd0 : (t2s - t1s);
    wire [31:0] a1s = t1s + cor, a4s = t4s + cor;

    function automatic logic [32:0] sdiff(input logic [31:0] as, af, bs, bf);
        logic [31:0] g, f;
        logic signed [31:0] gs;
        logic w;
        g = as - bs - {31'd0, af < bf};
        f = af - bf;
        gs = signed'(g);
        w = (gs >= RANGE_LIMIT) || (gs < -RANGE_LIMIT);
        return {w, g[31-MS_SHIFT:0], f[31:FRAC_SHIFT]};
    endfunction

    wire [32:0] e41 = sdiff(a4s, t4f, a1s, t1f);
    wire [32:0] e32 = sdiff(t3s, t3f, t2s, t2f);
    wire [32:0] e21 = sdiff(t2s, t2f, a1s, t1f);
    wire [32:0] e34 = sdiff(t3s, t3f, a4s, t4f);
    wire signed [32:0] osum = {e21[31], e21[31:0]} + {e34[31], e34[31:0]};

    // divider step
    wire [64:0] rsh = {rem_reg[63:0], num_reg[63]};
    wire ge = rsh >= {33'd0, den_reg};
    wire [64:0] rnew = ge ? rsh - {33'd0, den_reg} : rsh;

    // accumulate
    wire [31:0] r_w = quo_reg[31:0];
    wire signed [63:0] prod = 64'(off_reg) * signed'({32'd0, r_w});
    wire signed [64:0] ssum = {wsum_reg[63], wsum_reg} + {prod[63], prod};
    wire [32:0] tsum = {1'b0, wtot_reg} + {1'b0, r_w};
    wire signed [63:0] qs = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            coarse_done_reg <= 1'b0;
            coarse_reg <= '0;
            skew_reg <= '0;
            wsum_reg <= '0;
            wtot_reg <= '0;
            count_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    in_reg <= s_tdata[IN_BITS-1:0];
                    last_reg <= s_tlast;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    acc_reg <= acc_w;
                    if (acc_w) begin
                        if (!coarse_done_reg) begin
                            coarse_done_reg <= 1'b1;
                            coarse_reg <= t2s - t1s;
                        end
                        warn_reg <= e41[32] | e32[32] | e21[32] | e34[32];
                        rtt_reg <= e41[31:0] - e32[31:0];
                        off_reg <= osum[32:1];
                    end else begin
                        warn_reg <= 1'b0;
                        rtt_reg <= '0;
                        off_reg <= '0;
                    end
                    if (acc_w && count_reg < CAP) begin
                        state_reg <= ST_RECIP;
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        num_reg <= 64'd1 << WEIGHT_FRAC_BITS;
                        den_reg <= (signed'(e41[31:0] - e32[31:0]) >= 1) ?
                                   (e41[31:0] - e32[31:0]) : 32'd1;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_RECIP, ST_DIV: begin
                    rem_reg <= rnew;
                    num_reg <= {num_reg[62:0], 1'b0};
                    quo_reg <= {quo_reg[62:0], ge};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                        state_reg <= (state_reg == ST_RECIP) ? ST_ACC : ST_SKEW;
                end
                ST_ACC: begin
                    if (ssum[64] != ssum[63])
                        wsum_reg <= ssum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    else
                        wsum_reg <= ssum[63:0];
                    wtot_reg <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                    count_reg <= count_reg + 5'd1;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    used_reg <= count_reg;
                    state_reg <= ST_OUT;
                    if (last_reg) begin
                        wsum_reg <= '0;
                        wtot_reg <= '0;
                        count_reg <= '0;
                        coarse_done_reg <= 1'b0;
                        if (count_reg != 5'd0 && wtot_reg != 32'd0) begin
                            neg_reg <= wsum_reg[63];
                            num_reg <= wsum_reg[63] ? -wsum_reg : wsum_reg;
                            den_reg <= wtot_reg;
                            rem_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_SKEW: begin
                    // finished divide: clamp quotient into skew
                    if (!neg_reg && quo_reg > 64'h7FFF_FFFF)
                        skew_reg <= 32'sh7FFF_FFFF;
                    else if (neg_reg && quo_reg > 64'h8000_0000)
                        skew_reg <= 32'sh8000_0000;
                    else
                        skew_reg <= qs[31:0];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SNTP_ASSERT(a_excl, aclk, aresetn, !(s_tready && m_tvalid), "ready while result held")
    `SNTP_ASSERT(a_cap, aclk, aresetn, count_reg <= CAP, "count above cap")
    `SNTP_ASSERT_NEXT(a_idle, aclk, aresetn, m_tvalid && m_tready, s_tready, "no return to idle")
    `SNTP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
endmodule
